// ----- sv/assert_macros.svh -----
// Assertion macros shared by the calibrator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define GSRC_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Same-cycle implication.
`define GSRC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- sv/gsrc_pkg.sv -----
// Package: types, constants and helpers of the gas sensor ratio calibrator.
`timescale 1ns / 1ps

package gsrc_pkg;

   localparam int NUM_CH    = 3;
   localparam int CH_W      = 2;
   localparam int ADC_SHIFT = 15;
   localparam int DIV_N_W   = 42;
   localparam int DIV_D_W   = 32;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);
   localparam int SUM_W     = 40;

   localparam logic [16:0] ADC_FULL_SCALE = 17'd32768;
   localparam logic [12:0] VREF_MV        = 13'd5000;
   localparam logic [19:0] MOHM_PER_KOHM  = 20'd1000000;
   localparam logic [9:0]  MOHM_PER_OHM   = 10'd1000;
   localparam logic [9:0]  RATIO_SCALE    = 10'd1000;
   localparam logic [7:0]  CALIB_MAX      = 8'd255;

   localparam logic [6:0]  LOAD_RES_RESET = 7'd10;
   localparam logic [7:0]  CALIB_RESET    = 8'd100;

   typedef enum logic [2:0] {
      CSR_LOAD_A  = 3'd0,
      CSR_LOAD_B  = 3'd1,
      CSR_LOAD_C  = 3'd2,
      CSR_CLEAN_A = 3'd3,
      CSR_CLEAN_B = 3'd4,
      CSR_CLEAN_C = 3'd5,
      CSR_CALIB   = 3'd6
   } csr_index_type;

   typedef enum logic {
      KIND_START  = 1'b0,
      KIND_SAMPLE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      PH_OFF = 2'd0,
      PH_CAL = 2'd1,
      PH_ON  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_MEASURED    = 3'd0,
      ST_CAL_SAMPLE  = 3'd1,
      ST_CAL_DONE    = 3'd2,
      ST_NOT_ENABLED = 3'd3,
      ST_BAD_CH      = 3'd4,
      ST_ALREADY_ON  = 3'd5,
      ST_DEFAULT_ON  = 3'd6,
      ST_CALIBRATING = 3'd7
   } status_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  channel;
      logic [15:0] raw_sample;
   } req_type;

   typedef struct packed {
      logic [1:0]  channel_out;
      logic [2:0]  status;
      logic [1:0]  phase;
      logic [31:0] resistance_mohm;
      logic [15:0] ratio_milli;
      logic [31:0] baseline_mohm;
   } rsp_type;

   typedef struct packed {
      logic [NUM_CH-1:0][6:0]  load_res;
      logic [NUM_CH-1:0][19:0] clean_ro;
      logic [7:0]              calib_samples;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [31:0] sat32(input logic [DIV_N_W-1:0] q);
      return (q[DIV_N_W-1:32] != '0) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   function automatic logic [15:0] sat16(input logic [DIV_N_W-1:0] q);
      return (q[DIV_N_W-1:16] != '0) ? 16'hFFFF : q[15:0];
   endfunction

endpackage

// ----- sv/gsrc_csr.sv -----
// Configuration register bank of the calibrator.
`timescale 1ns / 1ps

module gsrc_csr import gsrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CH; i++) begin
            cfg_ff.load_res[i] <= LOAD_RES_RESET;
            cfg_ff.clean_ro[i] <= '0;
         end
         cfg_ff.calib_samples <= CALIB_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOAD_A:  cfg_ff.load_res[0]   <= csr_wdata[6:0];
            CSR_LOAD_B:  cfg_ff.load_res[1]   <= csr_wdata[6:0];
            CSR_LOAD_C:  cfg_ff.load_res[2]   <= csr_wdata[6:0];
            CSR_CLEAN_A: cfg_ff.clean_ro[0]   <= csr_wdata;
            CSR_CLEAN_B: cfg_ff.clean_ro[1]   <= csr_wdata;
            CSR_CLEAN_C: cfg_ff.clean_ro[2]   <= csr_wdata;
            CSR_CALIB:   cfg_ff.calib_samples <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/gsrc_divider.sv -----
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module gsrc_divider import gsrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   dvs_ff, dvs_in;
   logic [DIV_D_W:0]     rem_sh;
   logic [DIV_D_W:0]     rem_sub;
   logic                 ge;

   assign rem_sh  = {rem_ff, quo_ff[DIV_N_W-1]};
   assign ge      = rem_sh >= {1'b0, dvs_ff};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
         quo_in = {quo_ff[DIV_N_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- sv/gas_sensor_ratio_calibrator_core.sv -----
// Top level: gas sensor resistance, calibration and ratio sequencer.
// Start words, bad channels and samples on disabled channels answer without the divider;
// a sample runs the Rs division on the shared divider, and a second division when it ends
// calibration or yields a ratio against a nonzero baseline; a zero-mV sample skips the Rs
// division. One word at a time: req_ready rises with rsp_valid.
// Reset (synchronous, high): all channels disabled, state zeroed, registers to defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gas_sensor_ratio_calibrator_core import gsrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_MV,
      S_NUM,
      S_DIV_RS,
      S_POST,
      S_DIV_AVG,
      S_DIV_RATIO
   } state_type;
   localparam state_type S_OUT_UNUSED = S_IDLE;

   // The output stage has its own state register beside the sequencer state below.
   typedef enum logic {
      OUT_WAIT = 1'b0,
      OUT_LOAD = 1'b1
   } out_type;

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   state_type   state_ff, state_in;
   out_type     out_ff, out_in;

   // latched request word
   logic              kind_ff, kind_in;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic [15:0]       raw_ff, raw_in;

   // datapath registers
   logic [12:0]       mv_ff, mv_in;
   logic [19:0]       prod_ff, prod_in;
   logic [31:0]       rs_ff, rs_in;
   logic [15:0]       ratio_ff, ratio_in;
   status_type        status_ff, status_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // per-channel state
   phase_type         phase_ff [NUM_CH];
   logic [7:0]        count_ff [NUM_CH];
   logic [SUM_W-1:0]  sum_ff   [NUM_CH];
   logic [31:0]       base_ff  [NUM_CH];

   logic              ph_we, cnt_we, sum_we, base_we;
   phase_type         ph_new;
   logic [7:0]        cnt_new;
   logic [SUM_W-1:0]  sum_new;
   logic [31:0]       base_new;

   logic              bad_ch;
   phase_type         phase_cur;
   logic [7:0]        count_cur;
   logic [SUM_W-1:0]  sum_cur;
   logic [31:0]       base_cur;
   logic [16:0]       raw_clamp;
   logic [29:0]       mv_prod;
   logic [12:0]       mv_diff;
   logic [7:0]        target;
   logic [7:0]        count_inc;
   logic [SUM_W-1:0]  sum_acc;

   logic              div_waiting;
   logic              rsp_measured;

   gsrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gsrc_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign bad_ch    = ch_ff >= CH_W'(NUM_CH);
   assign phase_cur = phase_ff[ch_ff];
   assign count_cur = count_ff[ch_ff];
   assign sum_cur   = sum_ff[ch_ff];
   assign base_cur  = base_ff[ch_ff];

   // raw -> millivolts; full scale is a power of two, so the scale is a shift
   assign raw_clamp = ({1'b0, raw_ff} > ADC_FULL_SCALE) ? ADC_FULL_SCALE : {1'b0, raw_ff};
   assign mv_prod   = raw_clamp * VREF_MV;
   assign mv_diff   = VREF_MV - mv_ff;

   // calibration bookkeeping; a zero sample count acts as one
   assign target    = (cfg.calib_samples == 8'd0) ? 8'd1 : cfg.calib_samples;
   assign count_inc = (count_cur == CALIB_MAX) ? CALIB_MAX : count_cur + 8'd1;
   assign sum_acc   = sum_cur + SUM_W'(rs_ff);

   always_comb begin
      state_in     = state_ff;
      out_in       = out_ff;
      kind_in      = kind_ff;
      ch_in        = ch_ff;
      raw_in       = raw_ff;
      mv_in        = mv_ff;
      prod_in      = prod_ff;
      rs_in        = rs_ff;
      ratio_in     = ratio_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ph_we        = 1'b0;
      ph_new       = phase_cur;
      cnt_we       = 1'b0;
      cnt_new      = count_cur;
      sum_we       = 1'b0;
      sum_new      = sum_cur;
      base_we      = 1'b0;
      base_new     = base_cur;
      div_req      = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (out_ff == OUT_LOAD) begin
         // result word waits here until the output register is free
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_in           = 1'b1;
            rsp_in.channel_out     = ch_ff;
            rsp_in.status          = status_ff;
            rsp_in.phase           = bad_ch ? PH_OFF : phase_cur;
            rsp_in.resistance_mohm = rs_ff;
            rsp_in.ratio_milli     = ratio_ff;
            rsp_in.baseline_mohm   = bad_ch ? 32'd0 : base_cur;
            out_in                 = OUT_WAIT;
            state_in               = S_IDLE;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  kind_in  = req_data.kind;
                  ch_in    = req_data.channel;
                  raw_in   = req_data.raw_sample;
                  state_in = S_DECODE;
               end
            end
            S_DECODE: begin
               rs_in    = '0;
               ratio_in = '0;
               if (bad_ch) begin
                  status_in = ST_BAD_CH;
                  out_in    = OUT_LOAD;
               end else if (kind_ff == KIND_START) begin
                  if (phase_cur != PH_OFF) begin
                     status_in = ST_ALREADY_ON;
                  end else begin
                     base_we  = 1'b1;
                     base_new = 32'(cfg.clean_ro[ch_ff] * MOHM_PER_OHM);
                     cnt_we   = 1'b1;
                     cnt_new  = '0;
                     sum_we   = 1'b1;
                     sum_new  = '0;
                     ph_we    = 1'b1;
                     if (cfg.clean_ro[ch_ff] != '0) begin
                        ph_new    = PH_ON;
                        status_in = ST_DEFAULT_ON;
                     end else begin
                        ph_new    = PH_CAL;
                        status_in = ST_CALIBRATING;
                     end
                  end
                  out_in = OUT_LOAD;
               end else if (phase_cur == PH_OFF) begin
                  status_in = ST_NOT_ENABLED;
                  out_in    = OUT_LOAD;
               end else begin
                  mv_in    = mv_prod[ADC_SHIFT +: 13];
                  state_in = S_MV;
               end
            end
            S_MV: begin
               if (mv_ff == '0) begin
                  // no voltage across the load: resistance saturates
                  rs_in    = 32'hFFFF_FFFF;
                  state_in = S_POST;
               end else begin
                  prod_in  = mv_diff * cfg.load_res[ch_ff];
                  state_in = S_NUM;
               end
            end
            S_NUM: begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_N_W'(prod_ff * MOHM_PER_KOHM);
               div_req.divisor  = DIV_D_W'(mv_ff);
               state_in         = S_DIV_RS;
            end
            S_DIV_RS: begin
               if (div_rsp.done) begin
                  rs_in    = sat32(div_rsp.quotient);
                  state_in = S_POST;
               end
            end
            S_POST: begin
               if (phase_cur == PH_CAL) begin
                  sum_we  = 1'b1;
                  sum_new = sum_acc;
                  cnt_we  = 1'b1;
                  cnt_new = count_inc;
                  if (count_inc >= target) begin
                     div_req.start    = 1'b1;
                     div_req.dividend = DIV_N_W'(sum_acc);
                     div_req.divisor  = DIV_D_W'(count_inc);
                     state_in         = S_DIV_AVG;
                  end else begin
                     status_in = ST_CAL_SAMPLE;
                     out_in    = OUT_LOAD;
                  end
               end else if (base_cur == '0) begin
                  ratio_in  = '0;
                  status_in = ST_MEASURED;
                  out_in    = OUT_LOAD;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = DIV_N_W'(rs_ff * RATIO_SCALE);
                  div_req.divisor  = base_cur;
                  state_in         = S_DIV_RATIO;
               end
            end
            S_DIV_AVG: begin
               if (div_rsp.done) begin
                  base_we   = 1'b1;
                  base_new  = sat32(div_rsp.quotient);
                  ph_we     = 1'b1;
                  ph_new    = PH_ON;
                  status_in = ST_CAL_DONE;
                  out_in    = OUT_LOAD;
               end
            end
            S_DIV_RATIO: begin
               if (div_rsp.done) begin
                  ratio_in  = sat16(div_rsp.quotient);
                  status_in = ST_MEASURED;
                  out_in    = OUT_LOAD;
               end
            end
            default: begin
               state_in = S_OUT_UNUSED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      ch_ff     <= ch_in;
      raw_ff    <= raw_in;
      mv_ff     <= mv_in;
      prod_ff   <= prod_in;
      rs_ff     <= rs_in;
      ratio_ff  <= ratio_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         out_ff       <= OUT_WAIT;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CH; i++) begin
            phase_ff[i] <= PH_OFF;
            count_ff[i] <= '0;
            sum_ff[i]   <= '0;
            base_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         out_ff       <= out_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_CH; i++) begin
            if (ch_ff == CH_W'(i)) begin
               if (ph_we)   phase_ff[i] <= ph_new;
               if (cnt_we)  count_ff[i] <= cnt_new;
               if (sum_we)  sum_ff[i]   <= sum_new;
               if (base_we) base_ff[i]  <= base_new;
            end
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE) && (out_ff == OUT_WAIT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign div_waiting  = (state_ff == S_DIV_RS) || (state_ff == S_DIV_AVG) ||
                         (state_ff == S_DIV_RATIO);
   assign rsp_measured = rsp_valid_ff && (rsp_ff.status == ST_MEASURED);

   // divider is only launched when idle, and only finishes while the sequencer waits
   `GSRC_ASSERT_IMP(a_div_start_idle, clock, reset, div_req.start, !div_rsp.busy,
                    "divider restarted while busy")
   `GSRC_ASSERT_IMP(a_div_done_wait, clock, reset, div_rsp.done, div_waiting,
                    "divider done outside a wait state")
   // channel 0, if never started, has no calibration count
   `GSRC_ASSERT_IMP(a_off_count_zero, clock, reset, phase_ff[0] == PH_OFF,
                    count_ff[0] == 8'd0, "disabled channel holds a count")
   // a measured word always reports an enabled channel
   `GSRC_ASSERT_IMP(a_measured_on, clock, reset, rsp_measured, rsp_ff.phase == PH_ON,
                    "measured word on a channel that is not enabled")

endmodule

// ----- test/gas_sensor_ratio_calibrator_core_tb.sv -----
// Testbench of the calibrator: directed table, then random words under backpressure.
`timescale 1ns / 1ps

module gas_sensor_ratio_calibrator_core_tb import gsrc_pkg::*; ();

   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int DRAIN_CYCLES = 8;     // settle time after the last result of a phase
   localparam int TAIL_CYCLES  = 120;   // longer than the slowest sample
   localparam int STALL_LIMIT  = 3000;  // cycles with no transfer before giving up
   localparam int RAND_PHASES  = 8;
   localparam int PHASE_WORDS  = 100;

   // one row of the directed table; a fixed row carries its result typed in
   typedef struct {
      bit          reconfig;   // drain and load the second register set first
      kind_type    kind;
      logic [1:0]  ch;
      logic [15:0] raw;
      bit          fixed;
      rsp_type     reading;
   } dir_row_type;

   typedef struct {
      bit      fixed;
      rsp_type reading;
   } fixed_note_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [19:0] csr_wdata;

   gas_sensor_ratio_calibrator_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of registers and per-channel state
   logic [6:0]  load_kohm [NUM_CH];
   logic [19:0] clean_ohm [NUM_CH];
   logic [7:0]  calib_target;
   phase_type   ch_phase [NUM_CH];
   logic [7:0]  cal_count [NUM_CH];
   logic [SUM_W-1:0] cal_sum [NUM_CH];
   logic [31:0] base_mohm [NUM_CH];

   rsp_type        readings_due [$];
   fixed_note_type fixed_due [$];

   int  mismatches = 0;
   int  rsp_seen = 0;
   int  idle_cycles = 0;
   int  hold_left = 0;
   bit  hold_req = 1'b0;
   bit  calm = 1'b0;

   rsp_type        want;
   rsp_type        guess;
   fixed_note_type note;

   // Rs in milliohms from one raw ADC value
   function automatic logic [31:0] sensor_mohm(input logic [6:0] rl, input logic [15:0] raw);
      logic [63:0] r;
      logic [63:0] mv;
      logic [63:0] rs;
      r = 64'(raw);
      if (r > 64'(ADC_FULL_SCALE))
         r = 64'(ADC_FULL_SCALE);
      mv = r * 64'(VREF_MV) / 64'(ADC_FULL_SCALE);
      if (mv == 0)
         return 32'hFFFF_FFFF;          // zero millivolts saturates
      if (mv > 64'(VREF_MV))
         mv = 64'(VREF_MV);
      rs = (64'(VREF_MV) - mv) * 64'(rl) * 64'(MOHM_PER_KOHM) / mv;
      return (rs > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rs[31:0];
   endfunction

   // expected result of one accepted word; advances the predictor state
   function automatic rsp_type compute_reading(input req_type w);
      rsp_type     p;
      logic [1:0]  ch;
      logic [31:0] rs;
      logic [63:0] q;
      logic [7:0]  target;
      p = '0;
      ch = w.channel;
      p.channel_out = ch;
      if (ch >= NUM_CH) begin
         p.status = ST_BAD_CH;
         return p;
      end
      if (w.kind == KIND_START) begin
         if (ch_phase[ch] != PH_OFF) begin
            p.status = ST_ALREADY_ON;
         end else begin
            base_mohm[ch] = 32'(clean_ohm[ch]) * 32'(MOHM_PER_OHM);
            cal_count[ch] = '0;
            cal_sum[ch] = '0;
            if (base_mohm[ch] != 0) begin
               ch_phase[ch] = PH_ON;
               p.status = ST_DEFAULT_ON;
            end else begin
               ch_phase[ch] = PH_CAL;
               p.status = ST_CALIBRATING;
            end
         end
      end else if (ch_phase[ch] == PH_OFF) begin
         p.status = ST_NOT_ENABLED;
      end else begin
         rs = sensor_mohm(load_kohm[ch], w.raw_sample);
         p.resistance_mohm = rs;
         if (ch_phase[ch] == PH_CAL) begin
            target = (calib_target == 0) ? 8'd1 : calib_target;
            cal_sum[ch] = cal_sum[ch] + SUM_W'(rs);
            if (cal_count[ch] < CALIB_MAX)
               cal_count[ch] = cal_count[ch] + 8'd1;
            // a lowered target ends calibration at once
            if (cal_count[ch] >= target) begin
               q = 64'(cal_sum[ch]) / 64'(cal_count[ch]);
               base_mohm[ch] = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
               ch_phase[ch] = PH_ON;
               p.status = ST_CAL_DONE;
            end else begin
               p.status = ST_CAL_SAMPLE;
            end
         end else begin
            if (base_mohm[ch] != 0) begin
               q = 64'(rs) * 64'(RATIO_SCALE) / 64'(base_mohm[ch]);
               p.ratio_milli = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
            end
            p.status = ST_MEASURED;
         end
      end
      p.phase = ch_phase[ch];
      p.baseline_mohm = base_mohm[ch];
      return p;
   endfunction

   function automatic void note_reg(input csr_index_type idx, input logic [19:0] val);
      case (idx)
         CSR_LOAD_A, CSR_LOAD_B, CSR_LOAD_C: begin
            load_kohm[idx - CSR_LOAD_A] = val[6:0];
         end
         CSR_CLEAN_A, CSR_CLEAN_B, CSR_CLEAN_C: begin
            clean_ohm[idx - CSR_CLEAN_A] = val;
         end
         CSR_CALIB: begin
            calib_target = val[7:0];
         end
         default: ;
      endcase
   endfunction

   task automatic check_field(input string field, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: word %0d %s expected %0h actual %0h",
                  $time, rsp_seen, field, want_v, got_v);
         mismatches++;
      end
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver: random ready, a calm stretch, and one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 25);
         end
      end
   end

   // monitor: check each result word, then predict each accepted input word
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (readings_due.size() == 0) begin
               $display("%0t: word %0d expected nothing actual %p", $time, rsp_seen, rsp_data);
               mismatches++;
            end else begin
               want = readings_due.pop_front();
               check_field("channel_out", 32'(want.channel_out), 32'(rsp_data.channel_out));
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("phase", 32'(want.phase), 32'(rsp_data.phase));
               check_field("resistance_mohm", want.resistance_mohm, rsp_data.resistance_mohm);
               check_field("ratio_milli", 32'(want.ratio_milli), 32'(rsp_data.ratio_milli));
               check_field("baseline_mohm", want.baseline_mohm, rsp_data.baseline_mohm);
            end
            rsp_seen++;
         end
         if (req_valid && req_ready) begin
            note = fixed_due.pop_front();
            guess = compute_reading(req_data);
            readings_due.push_back(note.fixed ? note.reading : guess);
         end
      end
   end

   // watchdog on transfers
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, idle_cycles, readings_due.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // offer one word, with random gaps first; returns at the accepting edge
   task automatic send_word(input req_type w, input bit fixed, input rsp_type reading);
      fixed_note_type n;
      while (!calm && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      n.fixed = fixed;
      n.reading = reading;
      fixed_due.push_back(n);
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!(req_valid && req_ready))
         @(posedge clock);
   endtask

   // sender stops and waits until every result is back
   task automatic drain(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (readings_due.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // write every register, one per cycle, while idle
   task automatic program_regs(input logic [19:0] vals [7]);
      for (int i = 0; i <= CSR_CALIB; i++) begin
         csr_we <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         note_reg(csr_index_type'(i), vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic req_type random_word();
      req_type w;
      w.kind = ($urandom_range(99) < 15) ? KIND_START : KIND_SAMPLE;
      w.channel = ($urandom_range(99) < 8) ? 2'd3 : 2'($urandom_range(NUM_CH - 1));
      case ($urandom_range(9))
         0:       w.raw_sample = 16'($urandom_range(0, 7));          // around zero mV
         1:       w.raw_sample = 16'($urandom_range(32760, 32768));  // around full scale
         2:       w.raw_sample = 16'($urandom_range(32769, 65535));  // clamped
         3:       w.raw_sample = 16'hFFFF;
         default: w.raw_sample = 16'($urandom_range(0, 65535));
      endcase
      return w;
   endfunction

   function automatic logic [19:0] random_load();
      case ($urandom_range(5))
         0:       return 20'd0;
         1:       return 20'd1;
         2:       return 20'd100;
         3:       return 20'd127;
         default: return 20'($urandom_range(1, 100));
      endcase
   endfunction

   dir_row_type directed [$];

   initial begin
      logic [19:0] cfg_vals [7];
      req_type     w;
      dir_row_type row;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;

      for (int c = 0; c < NUM_CH; c++) begin
         load_kohm[c] = LOAD_RES_RESET;
         clean_ohm[c] = '0;
         ch_phase[c] = PH_OFF;
         cal_count[c] = '0;
         cal_sum[c] = '0;
         base_mohm[c] = '0;
      end
      calib_target = CALIB_RESET;

      // Directed table. Reset registers: 10 kohm loads, no clean baselines, 100 samples.
      directed.push_back('{0, KIND_SAMPLE, 2'd0, 16'h0000, 1,
                           rsp_type'{2'd0, ST_NOT_ENABLED, PH_OFF, 32'd0, 16'd0, 32'd0}});
      directed.push_back('{0, KIND_START, 2'd3, 16'hFFFF, 1,
                           rsp_type'{2'd3, ST_BAD_CH, PH_OFF, 32'd0, 16'd0, 32'd0}});
      directed.push_back('{0, KIND_SAMPLE, 2'd3, 16'h0000, 1,
                           rsp_type'{2'd3, ST_BAD_CH, PH_OFF, 32'd0, 16'd0, 32'd0}});
      directed.push_back('{0, KIND_START, 2'd0, 16'h5A5A, 1,
                           rsp_type'{2'd0, ST_CALIBRATING, PH_CAL, 32'd0, 16'd0, 32'd0}});
      // start on a channel that is already calibrating
      directed.push_back('{0, KIND_START, 2'd0, 16'h0000, 1,
                           rsp_type'{2'd0, ST_ALREADY_ON, PH_CAL, 32'd0, 16'd0, 32'd0}});
      // zero millivolts saturates Rs
      directed.push_back('{0, KIND_SAMPLE, 2'd0, 16'h0000, 1,
                           rsp_type'{2'd0, ST_CAL_SAMPLE, PH_CAL, 32'hFFFF_FFFF, 16'd0, 32'd0}});
      // clamped to full scale: 5000 mV, Rs zero
      directed.push_back('{0, KIND_SAMPLE, 2'd0, 16'hFFFF, 1,
                           rsp_type'{2'd0, ST_CAL_SAMPLE, PH_CAL, 32'd0, 16'd0, 32'd0}});
      directed.push_back('{0, KIND_SAMPLE, 2'd0, 16'd7, 0, rsp_type'('0)});
      directed.push_back('{0, KIND_SAMPLE, 2'd0, 16'd16384, 0, rsp_type'('0)});
      directed.push_back('{0, KIND_SAMPLE, 2'd1, 16'd16384, 1,
                           rsp_type'{2'd1, ST_NOT_ENABLED, PH_OFF, 32'd0, 16'd0, 32'd0}});
      // second register set lowers calib_samples to zero mid-calibration: ends on next sample
      directed.push_back('{1, KIND_SAMPLE, 2'd0, 16'd30000, 0, rsp_type'('0)});
      directed.push_back('{0, KIND_SAMPLE, 2'd0, 16'd1, 0, rsp_type'('0)});
      directed.push_back('{0, KIND_SAMPLE, 2'd0, 16'd32767, 0, rsp_type'('0)});
      // default baseline of 1 ohm
      directed.push_back('{0, KIND_START, 2'd1, 16'h0000, 1,
                           rsp_type'{2'd1, ST_DEFAULT_ON, PH_ON, 32'd0, 16'd0, 32'd1000}});
      directed.push_back('{0, KIND_SAMPLE, 2'd1, 16'd16384, 0, rsp_type'('0)});  // ratio saturates
      directed.push_back('{0, KIND_SAMPLE, 2'd1, 16'd32767, 0, rsp_type'('0)});
      directed.push_back('{0, KIND_SAMPLE, 2'd1, 16'd40000, 0, rsp_type'('0)});
      directed.push_back('{0, KIND_START, 2'd2, 16'hFFFF, 1,
                           rsp_type'{2'd2, ST_CALIBRATING, PH_CAL, 32'd0, 16'd0, 32'd0}});
      // zero load resistor: Rs zero, so the baseline ends up zero
      directed.push_back('{0, KIND_SAMPLE, 2'd2, 16'd20000, 0, rsp_type'('0)});
      directed.push_back('{0, KIND_SAMPLE, 2'd2, 16'd100, 0, rsp_type'('0)});
      directed.push_back('{0, KIND_SAMPLE, 2'd2, 16'd0, 0, rsp_type'('0)});  // zero baseline ratio
      directed.push_back('{0, KIND_START, 2'd2, 16'h0000, 0, rsp_type'('0)});
      directed.push_back('{0, KIND_START, 2'd3, 16'h8000, 1,
                           rsp_type'{2'd3, ST_BAD_CH, PH_OFF, 32'd0, 16'd0, 32'd0}});

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[k]) begin
         row = directed[k];
         if (row.reconfig) begin
            drain(DRAIN_CYCLES);
            cfg_vals[CSR_LOAD_A]  = 20'd127;
            cfg_vals[CSR_LOAD_B]  = 20'd1;
            cfg_vals[CSR_LOAD_C]  = 20'd0;
            cfg_vals[CSR_CLEAN_A] = 20'hFFFFF;
            cfg_vals[CSR_CLEAN_B] = 20'd1;
            cfg_vals[CSR_CLEAN_C] = 20'd0;
            cfg_vals[CSR_CALIB]   = 20'd0;
            program_regs(cfg_vals);
         end
         w.kind = row.kind;
         w.channel = row.ch;
         w.raw_sample = row.raw;
         send_word(w, row.fixed, row.reading);
      end

      // Random phases, a fresh register set between them.
      for (int p = 0; p < RAND_PHASES; p++) begin
         drain(DRAIN_CYCLES);
         calm = (p == 2);
         for (int i = 0; i <= CSR_CALIB; i++) begin
            if (i <= CSR_LOAD_C)
               cfg_vals[i] = random_load();
            else if (i <= CSR_CLEAN_C)
               cfg_vals[i] = ($urandom_range(3) == 0) ? 20'hFFFFF : 20'($urandom_range(0, 1048575));
            else
               cfg_vals[i] = 20'($urandom_range(0, 255));
         end
         // one phase with every load and the sample count at the top, one near the bottom
         if (p == 0) begin
            cfg_vals[CSR_LOAD_A] = 20'd127;
            cfg_vals[CSR_LOAD_B] = 20'd127;
            cfg_vals[CSR_LOAD_C] = 20'd127;
            cfg_vals[CSR_CALIB]  = 20'd255;
         end else if (p == 1) begin
            cfg_vals[CSR_LOAD_A]  = 20'd1;
            cfg_vals[CSR_LOAD_B]  = 20'd0;
            cfg_vals[CSR_LOAD_C]  = 20'd1;
            cfg_vals[CSR_CLEAN_B] = 20'd0;
            cfg_vals[CSR_CALIB]   = 20'd1;
         end
         program_regs(cfg_vals);
         if (p == 4)
            hold_req = 1'b1;   // receiver stalls long; the input backs up behind it
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (p == 5 && n == PHASE_WORDS / 2)
               drain(1);       // sender waits for every result, no register change
            send_word(random_word(), 1'b0, rsp_type'('0));
         end
      end
      calm = 1'b0;

      drain(TAIL_CYCLES);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+sv
sv/gsrc_pkg.sv
sv/gsrc_csr.sv
sv/gsrc_divider.sv
sv/gas_sensor_ratio_calibrator_core.sv
test/gas_sensor_ratio_calibrator_core_tb.sv
